// File: sv/biquad_tdf2_filter_core_assert.svh
// Assertion macros for the biquad filter core
`ifndef BIQUAD_TDF2_FILTER_CORE_ASSERT_SVH
`define BIQUAD_TDF2_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define BQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define BQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bq_tdf2_pkg.sv
// Shared types, constants and command encodings of the biquad filter core
`timescale 1ns / 1ps
package bq_tdf2_pkg;

  localparam int ChannelsDef = 2;
  localparam int SampleW     = 24;
  localparam int CoefW       = 24;
  localparam int ProdW       = 48;
  localparam int StateW      = 48;
  localparam int AccW        = 50;
  localparam int PaddrW      = 5;
  localparam int PdataW      = 32;
  localparam int RegIdxW     = 3;

  localparam logic [RegIdxW-1:0] RegB0 = 3'd0;
  localparam logic [RegIdxW-1:0] RegB1 = 3'd1;
  localparam logic [RegIdxW-1:0] RegB2 = 3'd2;
  localparam logic [RegIdxW-1:0] RegA1 = 3'd3;
  localparam logic [RegIdxW-1:0] RegA2 = 3'd4;

  localparam logic signed [CoefW-1:0] CoefB0Reset = 24'sd4194304;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_in;
    logic                      chan;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic                      chan_out;
  } out_word_t;

  typedef struct packed {
    logic signed [CoefW-1:0] b0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic signed [CoefW-1:0] a1;
    logic signed [CoefW-1:0] a2;
  } coef_t;

  typedef enum logic [2:0] {
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A1,
    COEF_A2
  } coef_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_LOAD_D2,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_B0,
    ST_OUT_Y,
    ST_ADD_D2,
    ST_SUB_A1,
    ST_WR_D1,
    ST_WR_D2
  } ctrl_state_e;

  typedef struct packed {
    logic      in_load;
    logic      mul_en;
    coef_sel_e coef_sel;
    logic      use_y;
    acc_op_e   acc_op;
    logic      y_load;
    logic      d1_we;
    logic      d2_we;
    logic      out_load;
  } dp_cmd_t;

endpackage

// File: sv/biquad_tdf2_filter_core.sv
// Top level of the transposed direct form II biquad filter core
`timescale 1ns / 1ps
// Input channel: in_valid_i / in_stall_o carry one word per sample, a Q1.23
//   sample and its channel number. A word is taken when valid is high and
//   stall is low; stall is high while a sample is being processed.
// Output channel: out_valid_o / out_stall_i carry the rounded, saturated
//   Q1.23 result and the same channel number, one word per input word.
// Configuration: APB-style port, coefficients b0, b1, b2, a1, a2 at byte
//   addresses 0, 4, 8, 12, 16 (signed Q2.22); write only while idle.
// Sequencing: the five products run one after another through a single
//   24x24 multiplier; the sequencer accepts a word, then steps through
//   multiply, round and state update, and takes no new word until it is
//   back in idle.
// The output register frees the input side: a new word is taken while a
//   finished result waits. When the receiver stalls past the next sample's
//   update, the sequencer holds on its final step until the register frees.
// Reset: coefficients return to b0 = 1.0 and the rest 0, all delay states
//   of every channel clear to zero, and both channels go idle.
module biquad_tdf2_filter_core
  import bq_tdf2_pkg::*;
#(
  parameter int CHANNELS = ChannelsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  coef_t   coef;
  dp_cmd_t cmd;

  bq_tdf2_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef)
  );

  bq_tdf2_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  bq_tdf2_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .coef_i     (coef),
    .cmd_i      (cmd),
    .out_word_o (out_word_o)
  );

`include "biquad_tdf2_filter_core_assert.svh"

  `BQ_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
                  "input taken while a sample is still in flight")
  `BQ_ASSERT_NEXT(a_d1_before_d2, cmd.d1_we, in_stall_o && !cmd.d1_we,
                  "sequencer released input between state writes")
  `BQ_ASSERT_NOW(a_out_with_state, cmd.out_load, cmd.d2_we && in_stall_o,
                 "result loaded without finishing the state update")

endmodule

// File: sv/bq_tdf2_regs.sv
// Coefficient register file behind the APB-style configuration port
`timescale 1ns / 1ps
module bq_tdf2_regs
  import bq_tdf2_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output coef_t             coef_o
);

  coef_t                    coef_q;
  logic                     wr_en;
  logic [RegIdxW-1:0]       reg_idx;
  logic signed [CoefW-1:0]  wr_val;
  logic signed [CoefW-1:0]  rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PaddrW-1:2];
  assign wr_val  = pwdata[CoefW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= CoefB0Reset;
      coef_q.b1 <= '0;
      coef_q.b2 <= '0;
      coef_q.a1 <= '0;
      coef_q.a2 <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        RegB0: coef_q.b0 <= wr_val;
        RegB1: coef_q.b1 <= wr_val;
        RegB2: coef_q.b2 <= wr_val;
        RegA1: coef_q.a1 <= wr_val;
        RegA2: coef_q.a2 <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegB0:   rd_val = coef_q.b0;
      RegB1:   rd_val = coef_q.b1;
      RegB2:   rd_val = coef_q.b2;
      RegA1:   rd_val = coef_q.a1;
      RegA2:   rd_val = coef_q.a2;
      default: rd_val = '0;
    endcase
  end

  assign prdata = {{(PdataW-CoefW){rd_val[CoefW-1]}}, rd_val};
  assign coef_o = coef_q;

endmodule

// File: sv/bq_tdf2_ctrl.sv
// Sequencer that steps one sample through the shared multiplier
`timescale 1ns / 1ps
module bq_tdf2_ctrl
  import bq_tdf2_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.coef_sel = COEF_B0;
    cmd_o.acc_op   = ACC_HOLD;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = ST_MUL_B0;
        end
      end
      ST_MUL_B0: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.coef_sel = COEF_B0;
        state_d        = ST_OUT_Y;
      end
      ST_OUT_Y: begin
        cmd_o.y_load   = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.coef_sel = COEF_B1;
        state_d        = ST_ADD_D2;
      end
      ST_ADD_D2: begin
        cmd_o.acc_op   = ACC_LOAD_D2;
        cmd_o.mul_en   = 1'b1;
        cmd_o.coef_sel = COEF_A1;
        cmd_o.use_y    = 1'b1;
        state_d        = ST_SUB_A1;
      end
      ST_SUB_A1: begin
        cmd_o.acc_op   = ACC_SUB;
        cmd_o.mul_en   = 1'b1;
        cmd_o.coef_sel = COEF_B2;
        state_d        = ST_WR_D1;
      end
      ST_WR_D1: begin
        cmd_o.d1_we    = 1'b1;
        cmd_o.acc_op   = ACC_LOAD;
        cmd_o.mul_en   = 1'b1;
        cmd_o.coef_sel = COEF_A2;
        cmd_o.use_y    = 1'b1;
        state_d        = ST_WR_D2;
      end
      ST_WR_D2: begin
        // hold until the output register can take the word
        if (out_free) begin
          cmd_o.d2_we    = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: sv/bq_tdf2_dp.sv
// Datapath: shared multiplier, accumulator, rounding and channel delay states
`timescale 1ns / 1ps
module bq_tdf2_dp
  import bq_tdf2_pkg::*;
#(
  parameter int CHANNELS = ChannelsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  coef_t     coef_i,
  input  dp_cmd_t   cmd_i,
  output out_word_t out_word_o
);

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(64'sd2097152);
  localparam logic signed [AccW-1:0] OutMax    = AccW'(64'sd8388607);
  localparam logic signed [AccW-1:0] OutMin    = AccW'(-64'sd8388608);

  function automatic logic signed [StateW-1:0] sat_state(input logic signed [AccW-1:0] v);
    logic signed [StateW-1:0] r;
    if ((v[AccW-1:StateW-1] == '0) || (v[AccW-1:StateW-1] == '1)) begin
      r = v[StateW-1:0];
    end else if (v[AccW-1]) begin
      r = {1'b1, {(StateW-1){1'b0}}};
    end else begin
      r = {1'b0, {(StateW-1){1'b1}}};
    end
    return r;
  endfunction

  logic signed [SampleW-1:0] x_q;
  logic                      chan_q;
  logic [IdxW-1:0]           idx_q;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic signed [SampleW-1:0] y_q, y_d;
  logic signed [StateW-1:0]  d1_q [CHANNELS];
  logic signed [StateW-1:0]  d2_q [CHANNELS];
  out_word_t                 out_word_q;

  logic signed [CoefW-1:0]   mul_coef;
  logic signed [SampleW-1:0] mul_data;
  logic signed [ProdW-1:0]   prod_d;
  logic signed [AccW-1:0]    prod_x;
  logic signed [AccW-1:0]    acc_diff;
  logic signed [AccW-1:0]    sum_y;
  logic signed [AccW-1:0]    shift_y;

  always_comb begin
    case (cmd_i.coef_sel)
      COEF_B0: mul_coef = coef_i.b0;
      COEF_B1: mul_coef = coef_i.b1;
      COEF_B2: mul_coef = coef_i.b2;
      COEF_A1: mul_coef = coef_i.a1;
      COEF_A2: mul_coef = coef_i.a2;
      default: mul_coef = coef_i.b0;
    endcase
  end

  assign mul_data = cmd_i.use_y ? y_q : x_q;
  assign prod_d   = mul_coef * mul_data;
  assign prod_x   = AccW'(prod_q);
  assign acc_diff = acc_q - prod_x;

  // round half up from 45 to 23 fractional bits, then clamp to Q1.23
  assign sum_y   = prod_x + AccW'(d1_q[idx_q]) + RoundHalf;
  assign shift_y = sum_y >>> 22;

  always_comb begin
    if (shift_y > OutMax) begin
      y_d = OutMax[SampleW-1:0];
    end else if (shift_y < OutMin) begin
      y_d = OutMin[SampleW-1:0];
    end else begin
      y_d = shift_y[SampleW-1:0];
    end
  end

  always_comb begin
    case (cmd_i.acc_op)
      ACC_HOLD:    acc_d = acc_q;
      ACC_LOAD:    acc_d = prod_x;
      ACC_LOAD_D2: acc_d = prod_x + AccW'(d2_q[idx_q]);
      ACC_SUB:     acc_d = acc_diff;
      default:     acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      x_q    <= in_word_i.sample_in;
      chan_q <= in_word_i.chan;
      idx_q  <= (CHANNELS > 1) ? IdxW'(in_word_i.chan) : '0;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.y_load) begin
      y_q <= y_d;
    end
    acc_q <= acc_d;
    if (cmd_i.out_load) begin
      out_word_q.sample_out <= y_q;
      out_word_q.chan_out   <= chan_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else begin
      if (cmd_i.d1_we) begin
        d1_q[idx_q] <= sat_state(acc_q);
      end
      if (cmd_i.d2_we) begin
        d2_q[idx_q] <= sat_state(acc_diff);
      end
    end
  end

  assign out_word_o = out_word_q;

endmodule
